/* hw/rtl/bbl_pkg.sv */
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared types and constants for the byte-budget LRU cache tracker.
// ----------------------------------------------------------------------------
package bbl_pkg;

  localparam int CMD_W       = 2;
  localparam int IDX_IN_W    = 4;
  localparam int SIZE_W      = 32;
  localparam int BYTES_W     = 48;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_TOUCH     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT_ALL = 2'd2;

  localparam logic STATUS_APPLIED = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_TOUCH_CHK,
    S_MV_1,
    S_MV_2,
    S_MV_3,
    S_MV_4,
    S_INS_LNK,
    S_EV_CHK,
    S_EV_UPD,
    S_EV_LNK,
    S_RM_CHK,
    S_RM_NW,
    S_RM_OD,
    S_EA_CHK,
    S_EA_UPD,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_FETCH,
    R_SHOW
  } res_state_t;

  // Per-field write enables of the entry memory
  typedef struct packed {
    logic held;
    logic size;
    logic older;
    logic newer;
  } bbl_wmask_t;

  // Requests from the sequencer to the result buffer
  typedef struct packed {
    logic push;
    logic done;
    logic status;
  } bbl_res_req_t;

endpackage

/* hw/rtl/bbl_entry_mem.sv */
// ----------------------------------------------------------------------------
// bbl_entry_mem
// Per-block entry store: held flag, size and recency links, one write port
// with field enables and one read port with registered data.
// ----------------------------------------------------------------------------
module bbl_entry_mem #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic                                clk,
  input  bbl_pkg::bbl_wmask_t                 wr_mask,
  input  logic [$clog2(NUM_BLOCKS)-1:0]       wr_addr,
  input  logic                                wr_held,
  input  logic [bbl_pkg::SIZE_W-1:0]          wr_size,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]     wr_older,
  input  logic [$clog2(NUM_BLOCKS+1)-1:0]     wr_newer,
  input  logic                                rd_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0]       rd_addr,
  output logic                                rd_held,
  output logic [bbl_pkg::SIZE_W-1:0]          rd_size,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]     rd_older,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]     rd_newer
);
  import bbl_pkg::*;

  localparam int LINK_W = $clog2(NUM_BLOCKS + 1);

  typedef struct packed {
    logic              held;
    logic [SIZE_W-1:0] size;
    logic [LINK_W-1:0] older;
    logic [LINK_W-1:0] newer;
  } entry_t;

  entry_t mem_r [NUM_BLOCKS];
  entry_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_mask.held)  mem_r[wr_addr].held  <= wr_held;
    if (wr_mask.size)  mem_r[wr_addr].size  <= wr_size;
    if (wr_mask.older) mem_r[wr_addr].older <= wr_older;
    if (wr_mask.newer) mem_r[wr_addr].newer <= wr_newer;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem_r[rd_addr];
  end

  assign rd_held  = rd_r.held;
  assign rd_size  = rd_r.size;
  assign rd_older = rd_r.older;
  assign rd_newer = rd_r.newer;

endmodule

/* hw/rtl/bbl_result_buf.sv */
// ----------------------------------------------------------------------------
// bbl_result_buf
// Collects released block indices of one command, then plays them out as
// result beats carrying the final byte total.
// ----------------------------------------------------------------------------
module bbl_result_buf #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bbl_pkg::bbl_res_req_t             req,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     push_idx,
  input  logic [bbl_pkg::BYTES_W-1:0]       done_total,
  output logic                              busy,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_evicted,
  output logic [bbl_pkg::IDX_IN_W-1:0]      out_index,
  output logic [bbl_pkg::BYTES_W-1:0]       out_bytes,
  output logic                              out_status,
  output logic                              out_last
);
  import bbl_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic [IDX_W-1:0] rel_mem [NUM_BLOCKS];
  logic [IDX_W-1:0] rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  res_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [BYTES_W-1:0] total_r, total_nxt;
  logic              evicted_r, evicted_nxt;
  logic [IDX_W-1:0]  index_r, index_nxt;
  logic              status_r, status_nxt;
  logic              last_r, last_nxt;
  logic              is_final;

  assign is_final = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      R_IDLE: begin
        if (req.done) state_nxt = (count_r == '0) ? R_SHOW : R_FETCH;
      end
      R_FETCH: state_nxt = R_SHOW;
      R_SHOW: begin
        if (out_ready) state_nxt = last_r ? R_IDLE : R_FETCH;
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    total_nxt   = total_r;
    evicted_nxt = evicted_r;
    index_nxt   = index_r;
    status_nxt  = status_r;
    last_nxt    = last_r;
    rd_en       = 1'b0;
    rd_addr     = ptr_r;
    unique case (state_r)
      R_IDLE: begin
        if (req.push) count_nxt = count_r + CNT_W'(1);
        if (req.done) begin
          total_nxt = done_total;
          ptr_nxt   = '0;
          if (count_r == '0) begin
            evicted_nxt = 1'b0;
            index_nxt   = '0;
            status_nxt  = req.status;
            last_nxt    = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      R_FETCH: begin
        evicted_nxt = 1'b1;
        index_nxt   = rd_data_r;
        status_nxt  = STATUS_APPLIED;
        last_nxt    = is_final;
      end
      R_SHOW: begin
        if (out_ready) begin
          if (last_r) begin
            count_nxt = '0;
          end else begin
            ptr_nxt = ptr_r + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = ptr_r + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.push) rel_mem[count_r[IDX_W-1:0]] <= push_idx;
    if (rd_en) rd_data_r <= rel_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    ptr_r     <= ptr_nxt;
    total_r   <= total_nxt;
    evicted_r <= evicted_nxt;
    index_r   <= index_nxt;
    status_r  <= status_nxt;
    last_r    <= last_nxt;
  end

  assign busy        = (state_r != R_IDLE);
  assign out_valid   = (state_r == R_SHOW);
  assign out_evicted = evicted_r;
  assign out_index   = IDX_IN_W'(index_r);
  assign out_bytes   = total_r;
  assign out_status  = status_r;
  assign out_last    = last_r;

endmodule

/* hw/rtl/byte_budget_lru_cache_tracker_core.sv */
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_tracker_core
// Recency-ordered block tracker under a byte budget, built around one entry
// memory holding held flags, sizes and doubly linked recency links.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command beat (touch, remove, evict all) per accepted beat.
//   out_* : one beat per released block in release order, or a single beat
//           when nothing is released; tlast marks the final beat of a command.
//   cfg_* : write of the byte budget; always ready, take it while idle.
// Steps: every walk step is a read of the entry memory (registered read
//   data) followed by its write-backs. Result beats then leave through the
//   result buffer, each read from its store before it is shown; the next
//   command is taken once the last beat has gone.
// Reset: a clearing pass over every entry drops every held flag; no command
//   is accepted until it ends. The budget resets to zero.
// Stall: while out_tready is low the current beat holds and no command is
//   accepted.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_tracker_core #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tuser: cmd[1:0]
  // tdata: block_index[3:0], block_size[35:4], zero pad [39:36]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bbl_pkg::CMD_W-1:0]          in_tuser,
  input  logic [bbl_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: evicted[0]
  // tdata: evicted_index[3:0], bytes_in_use[51:4], status[52], zero pad [55:53]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic                               out_tuser,
  output logic [bbl_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bbl_pkg::BYTES_W-1:0]        cfg_data
);
  import bbl_pkg::*;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_BLOCKS);

  // Input beat fields
  logic [CMD_W-1:0]    in_cmd;
  logic [IDX_IN_W-1:0] in_blk;
  logic [SIZE_W-1:0]   in_size;
  logic                in_acc;
  logic                blk_ok;
  assign in_cmd  = in_tuser;
  assign in_blk  = in_tdata[3:0];
  assign in_size = in_tdata[35:4];
  assign in_acc  = in_tvalid & in_tready;
  assign blk_ok  = 32'(in_blk) < 32'(NUM_BLOCKS);

  // Sequencer state
  seq_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]   clr_ptr_r, clr_ptr_nxt;
  logic [LINK_W-1:0]  newest_r, newest_nxt;
  logic [LINK_W-1:0]  oldest_r, oldest_nxt;
  logic [BYTES_W-1:0] total_r, total_nxt;
  logic [BYTES_W-1:0] budget_r, budget_nxt;
  logic [IDX_W-1:0]   blk_r, blk_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [LINK_W-1:0]  nw_r, nw_nxt;
  logic [LINK_W-1:0]  od_r, od_nxt;
  logic [LINK_W-1:0]  cur_r, cur_nxt;
  logic               status_r, status_nxt;

  // Entry memory ports
  bbl_wmask_t         wr_mask;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_held;
  logic [SIZE_W-1:0]  wr_size;
  logic [LINK_W-1:0]  wr_older;
  logic [LINK_W-1:0]  wr_newer;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_held;
  logic [SIZE_W-1:0]  rd_size;
  logic [LINK_W-1:0]  rd_older;
  logic [LINK_W-1:0]  rd_newer;

  // Result buffer ports
  bbl_res_req_t       res_req;
  logic [IDX_W-1:0]   push_idx;
  logic               res_busy;
  logic               res_evicted;
  logic [IDX_IN_W-1:0] res_index;
  logic [BYTES_W-1:0] res_bytes;
  logic               res_status;

  // Byte arithmetic
  logic [BYTES_W:0]   add_sum;
  logic [BYTES_W-1:0] add_sat;
  logic [BYTES_W-1:0] sub_sat;
  logic               over_budget;

  assign add_sum     = {1'b0, total_r} + (BYTES_W+1)'(size_r);
  assign add_sat     = add_sum[BYTES_W] ? BYTES_MAX : add_sum[BYTES_W-1:0];
  assign sub_sat     = (total_r >= BYTES_W'(rd_size)) ? (total_r - BYTES_W'(rd_size)) : '0;
  assign over_budget = (total_r > budget_r) && (oldest_r != NIL) && (oldest_r != newest_r);

  assign in_tready = (state_r == S_IDLE) && !res_busy;
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_ptr_r == IDX_W'(NUM_BLOCKS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          priority case (in_cmd)
            CMD_TOUCH:     state_nxt = (budget_r != '0 && blk_ok) ? S_TOUCH_CHK : S_DONE;
            CMD_REMOVE:    state_nxt = blk_ok ? S_RM_CHK : S_DONE;
            CMD_EVICT_ALL: state_nxt = S_EA_CHK;
            default:       state_nxt = S_DONE;
          endcase
        end
      end
      S_TOUCH_CHK: begin
        if (rd_held) begin
          state_nxt = (newest_r == LINK_W'(blk_r)) ? S_DONE : S_MV_1;
        end else begin
          state_nxt = (newest_r != NIL) ? S_INS_LNK : S_EV_CHK;
        end
      end
      S_MV_1:    state_nxt = (od_r != NIL) ? S_MV_2 : S_MV_3;
      S_MV_2:    state_nxt = S_MV_3;
      S_MV_3:    state_nxt = S_MV_4;
      S_MV_4:    state_nxt = S_DONE;
      S_INS_LNK: state_nxt = S_EV_CHK;
      S_EV_CHK:  state_nxt = over_budget ? S_EV_UPD : S_DONE;
      S_EV_UPD:  state_nxt = S_EV_LNK;
      S_EV_LNK:  state_nxt = S_EV_CHK;
      S_RM_CHK:  state_nxt = rd_held ? S_RM_NW : S_DONE;
      S_RM_NW:   state_nxt = S_RM_OD;
      S_RM_OD:   state_nxt = S_DONE;
      S_EA_CHK:  state_nxt = (cur_r != NIL) ? S_EA_UPD : S_DONE;
      S_EA_UPD:  state_nxt = S_EA_CHK;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and result requests
  always_comb begin
    clr_ptr_nxt = clr_ptr_r;
    newest_nxt  = newest_r;
    oldest_nxt  = oldest_r;
    total_nxt   = total_r;
    budget_nxt  = cfg_valid ? cfg_data : budget_r;
    blk_nxt     = blk_r;
    size_nxt    = size_r;
    nw_nxt      = nw_r;
    od_nxt      = od_r;
    cur_nxt     = cur_r;
    status_nxt  = status_r;
    wr_mask     = '0;
    wr_addr     = '0;
    wr_held     = 1'b0;
    wr_size     = '0;
    wr_older    = NIL;
    wr_newer    = NIL;
    rd_en       = 1'b0;
    rd_addr     = '0;
    res_req     = '0;
    push_idx    = '0;

    unique case (state_r)
      S_CLEAR: begin
        // sweep held flags clear after reset
        wr_mask.held = 1'b1;
        wr_addr      = clr_ptr_r;
        clr_ptr_nxt  = clr_ptr_r + IDX_W'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          blk_nxt    = IDX_W'(in_blk);
          size_nxt   = in_size;
          cur_nxt    = newest_r;
          status_nxt = (in_cmd == CMD_TOUCH && budget_r == '0) ? STATUS_IGNORED
                                                              : STATUS_APPLIED;
          rd_en      = 1'b1;
          rd_addr    = IDX_W'(in_blk);
        end
      end
      S_TOUCH_CHK: begin
        nw_nxt = rd_newer;
        od_nxt = rd_older;
        if (!rd_held) begin
          // insert at the newest end; old newest still in newest_r
          wr_mask    = '{held: 1'b1, size: 1'b1, older: 1'b1, newer: 1'b1};
          wr_addr    = blk_r;
          wr_held    = 1'b1;
          wr_size    = size_r;
          wr_older   = newest_r;
          wr_newer   = NIL;
          od_nxt     = newest_r;
          newest_nxt = LINK_W'(blk_r);
          if (oldest_r == NIL) oldest_nxt = LINK_W'(blk_r);
          total_nxt  = add_sat;
        end
      end
      S_MV_1: begin
        // unlink from the newer neighbour, which always exists here
        wr_mask.older = 1'b1;
        wr_addr       = IDX_W'(nw_r);
        wr_older      = od_r;
        if (od_r == NIL) oldest_nxt = nw_r;
      end
      S_MV_2: begin
        wr_mask.newer = 1'b1;
        wr_addr       = IDX_W'(od_r);
        wr_newer      = nw_r;
      end
      S_MV_3: begin
        wr_mask.older = 1'b1;
        wr_mask.newer = 1'b1;
        wr_addr       = blk_r;
        wr_older      = newest_r;
        wr_newer      = NIL;
      end
      S_MV_4: begin
        wr_mask.newer = 1'b1;
        wr_addr       = IDX_W'(newest_r);
        wr_newer      = LINK_W'(blk_r);
        newest_nxt    = LINK_W'(blk_r);
      end
      S_INS_LNK: begin
        wr_mask.newer = 1'b1;
        wr_addr       = IDX_W'(od_r);
        wr_newer      = LINK_W'(blk_r);
      end
      S_EV_CHK: begin
        if (over_budget) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(oldest_r);
        end
      end
      S_EV_UPD: begin
        // drop the oldest block; its newer neighbour becomes oldest
        wr_mask      = '{held: 1'b1, size: 1'b0, older: 1'b1, newer: 1'b1};
        wr_addr      = IDX_W'(oldest_r);
        res_req.push = 1'b1;
        push_idx     = IDX_W'(oldest_r);
        oldest_nxt   = rd_newer;
        total_nxt    = sub_sat;
      end
      S_EV_LNK: begin
        wr_mask.older = 1'b1;
        wr_addr       = IDX_W'(oldest_r);
        wr_older      = NIL;
      end
      S_RM_CHK: begin
        nw_nxt = rd_newer;
        od_nxt = rd_older;
        if (rd_held) begin
          wr_mask      = '{held: 1'b1, size: 1'b0, older: 1'b1, newer: 1'b1};
          wr_addr      = blk_r;
          res_req.push = 1'b1;
          push_idx     = blk_r;
          total_nxt    = sub_sat;
          if (rd_newer == NIL) newest_nxt = rd_older;
          if (rd_older == NIL) oldest_nxt = rd_newer;
        end
      end
      S_RM_NW: begin
        if (nw_r != NIL) begin
          wr_mask.older = 1'b1;
          wr_addr       = IDX_W'(nw_r);
          wr_older      = od_r;
        end
      end
      S_RM_OD: begin
        if (od_r != NIL) begin
          wr_mask.newer = 1'b1;
          wr_addr       = IDX_W'(od_r);
          wr_newer      = nw_r;
        end
      end
      S_EA_CHK: begin
        if (cur_r != NIL) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(cur_r);
        end else begin
          newest_nxt = NIL;
          oldest_nxt = NIL;
          total_nxt  = '0;
        end
      end
      S_EA_UPD: begin
        // release newest first, walk towards the oldest
        wr_mask      = '{held: 1'b1, size: 1'b0, older: 1'b1, newer: 1'b1};
        wr_addr      = IDX_W'(cur_r);
        res_req.push = 1'b1;
        push_idx     = IDX_W'(cur_r);
        cur_nxt      = rd_older;
      end
      S_DONE: begin
        res_req.done   = 1'b1;
        res_req.status = status_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_ptr_r <= '0;
      newest_r  <= NIL;
      oldest_r  <= NIL;
      total_r   <= '0;
      budget_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      newest_r  <= newest_nxt;
      oldest_r  <= oldest_nxt;
      total_r   <= total_nxt;
      budget_r  <= budget_nxt;
    end
    blk_r    <= blk_nxt;
    size_r   <= size_nxt;
    nw_r     <= nw_nxt;
    od_r     <= od_nxt;
    cur_r    <= cur_nxt;
    status_r <= status_nxt;
  end

  bbl_entry_mem #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_entry_mem (
    .clk      (clk),
    .wr_mask  (wr_mask),
    .wr_addr  (wr_addr),
    .wr_held  (wr_held),
    .wr_size  (wr_size),
    .wr_older (wr_older),
    .wr_newer (wr_newer),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_held  (rd_held),
    .rd_size  (rd_size),
    .rd_older (rd_older),
    .rd_newer (rd_newer)
  );

  // total_r is final when the done request is raised
  bbl_result_buf #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_result_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (res_req),
    .push_idx    (push_idx),
    .done_total  (total_r),
    .busy        (res_busy),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_evicted (res_evicted),
    .out_index   (res_index),
    .out_bytes   (res_bytes),
    .out_status  (res_status),
    .out_last    (out_tlast)
  );

  assign out_tuser = res_evicted;
  assign out_tdata = {3'b000, res_status, res_bytes, res_index};

endmodule

/* dv/lru_tracker_checker.sv */
// ----------------------------------------------------------------------------
// lru_tracker_checker
// Watches the command, result and budget channels of the LRU tracker, keeps
// its own recency list and byte count, and compares every result beat field
// by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module lru_tracker_checker #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bbl_pkg::CMD_W-1:0]       in_tuser,
  input  logic [bbl_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            out_tuser,
  input  logic [bbl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bbl_pkg::BYTES_W-1:0]     cfg_data,
  input  logic                            drain_done,
  output int                              fail_count,
  output int                              beats_waiting,
  output int                              cmds_seen,
  output int                              releases_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import bbl_pkg::*;

  localparam logic [4:0] NIL_LINK = 5'(NUM_BLOCKS);

  typedef struct packed {
    logic               evicted;
    logic [3:0]         idx;
    logic [BYTES_W-1:0] bytes;
    logic               status;
    logic               last;
  } release_beat_t;

  logic               blk_held   [NUM_BLOCKS];
  logic [SIZE_W-1:0]  blk_bytes  [NUM_BLOCKS];
  logic [4:0]         link_older [NUM_BLOCKS];
  logic [4:0]         link_newer [NUM_BLOCKS];
  logic [4:0]         newest;
  logic [4:0]         oldest;
  logic [BYTES_W-1:0] bytes_held;
  logic [BYTES_W-1:0] budget;
  logic               leftovers_checked;

  release_beat_t      expected_beats [$];

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void unlink(input logic [4:0] b);
    logic [4:0] nw;
    logic [4:0] od;
    nw = link_newer[b];
    od = link_older[b];
    if (nw != NIL_LINK) link_older[nw] = od;
    else newest = od;
    if (od != NIL_LINK) link_newer[od] = nw;
    else oldest = nw;
    link_newer[b] = NIL_LINK;
    link_older[b] = NIL_LINK;
  endfunction

  function automatic void link_front(input logic [4:0] b);
    link_newer[b] = NIL_LINK;
    link_older[b] = newest;
    if (newest != NIL_LINK) link_newer[newest] = b;
    newest = b;
    if (oldest == NIL_LINK) oldest = b;
  endfunction

  function automatic void free_bytes(input logic [4:0] b);
    bytes_held = (bytes_held >= BYTES_W'(blk_bytes[b])) ?
                 bytes_held - BYTES_W'(blk_bytes[b]) : '0;
  endfunction

  // Apply one command to the shadow list and queue the beats it must produce
  function automatic void predict_command(input logic [CMD_W-1:0]  cmd,
                                          input logic [3:0]        b,
                                          input logic [SIZE_W-1:0] size);
    logic [4:0]    freed [$];
    logic [4:0]    walk;
    logic [4:0]    victim;
    logic [BYTES_W:0] grown;
    logic          ignored;
    release_beat_t beat;
    int            i;
    ignored = STATUS_APPLIED;
    case (cmd)
      CMD_TOUCH: begin
        if (budget == '0) begin
          ignored = STATUS_IGNORED;
        end else if (blk_held[b]) begin
          if (newest != {1'b0, b}) begin
            unlink({1'b0, b});
            link_front({1'b0, b});
          end
        end else begin
          grown = {1'b0, bytes_held} + (BYTES_W + 1)'(size);
          blk_held[b]  = 1'b1;
          blk_bytes[b] = size;
          bytes_held   = grown[BYTES_W] ? BYTES_MAX : grown[BYTES_W-1:0];
          link_front({1'b0, b});
          // shed oldest entries, never the one just inserted
          while (bytes_held > budget && oldest != NIL_LINK && oldest != newest &&
                 freed.size() < NUM_BLOCKS) begin
            victim = oldest;
            unlink(victim);
            blk_held[victim] = 1'b0;
            free_bytes(victim);
            freed.push_back(victim);
          end
        end
      end
      CMD_REMOVE: begin
        if (blk_held[b]) begin
          unlink({1'b0, b});
          blk_held[b] = 1'b0;
          free_bytes({1'b0, b});
          freed.push_back({1'b0, b});
        end
      end
      CMD_EVICT_ALL: begin
        walk = newest;
        while (walk != NIL_LINK && freed.size() < NUM_BLOCKS) begin
          freed.push_back(walk);
          walk = link_older[walk];
        end
        for (i = 0; i < NUM_BLOCKS; i++) begin
          blk_held[i]   = 1'b0;
          link_older[i] = NIL_LINK;
          link_newer[i] = NIL_LINK;
        end
        newest     = NIL_LINK;
        oldest     = NIL_LINK;
        bytes_held = '0;
      end
      default: ;
    endcase

    if (freed.size() == 0) begin
      beat = '{evicted: 1'b0, idx: 4'd0, bytes: bytes_held, status: ignored, last: 1'b1};
      expected_beats.push_back(beat);
    end else begin
      for (i = 0; i < freed.size(); i++) begin
        beat = '{evicted: 1'b1, idx: freed[i][3:0], bytes: bytes_held,
                 status: STATUS_APPLIED, last: (i == freed.size() - 1)};
        expected_beats.push_back(beat);
      end
      releases_seen += freed.size();
    end
  endfunction

  always @(posedge clk) begin
    release_beat_t want;
    release_beat_t got;
    int            i;
    if (!rst_n) begin
      for (i = 0; i < NUM_BLOCKS; i++) begin
        blk_held[i]   = 1'b0;
        blk_bytes[i]  = '0;
        link_older[i] = NIL_LINK;
        link_newer[i] = NIL_LINK;
      end
      newest            = NIL_LINK;
      oldest            = NIL_LINK;
      bytes_held        = '0;
      budget            = '0;
      leftovers_checked = 1'b0;
      fail_count        = 0;
      cmds_seen         = 0;
      releases_seen     = 0;
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) budget = cfg_data;

      if (in_tvalid && in_tready) begin
        cmds_seen++;
        predict_command(in_tuser, in_tdata[3:0], in_tdata[35:4]);
      end

      if (out_tvalid && out_tready) begin
        got = '{evicted: out_tuser, idx: out_tdata[3:0], bytes: out_tdata[51:4],
                status: out_tdata[52], last: out_tlast};
        if (expected_beats.size() == 0) begin
          report($sformatf("unexpected result beat, index %0d bytes %0d",
                           got.idx, got.bytes));
        end else begin
          want = expected_beats.pop_front();
          if (got.evicted !== want.evicted)
            report($sformatf("evicted flag %b, want %b", got.evicted, want.evicted));
          if (got.idx !== want.idx)
            report($sformatf("evicted index %0d, want %0d", got.idx, want.idx));
          if (got.bytes !== want.bytes)
            report($sformatf("bytes in use %0d, want %0d", got.bytes, want.bytes));
          if (got.status !== want.status)
            report($sformatf("status %b, want %b", got.status, want.status));
          if (got.last !== want.last)
            report($sformatf("tlast %b, want %b", got.last, want.last));
        end
      end

      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_beats.size() != 0)
          report($sformatf("%0d expected beats never arrived", expected_beats.size()));
      end
    end
    beats_waiting <= expected_beats.size();
  end

endmodule

/* dv/byte_budget_lru_cache_tracker_core_tb.sv */
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_tracker_core_tb
// Drives touch, remove and evict-all commands into the LRU tracker under a
// series of byte budgets, with random gaps on the command side and random
// back-pressure on the result side; the checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbl_pkg::*;

  localparam int NUM_BLOCKS = 16;
  localparam int PHASE_ITEMS = 24;
  // the one command code the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [CMD_W-1:0]       in_tuser   = '0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [BYTES_W-1:0]     cfg_data   = '0;
  logic                   drain_done = 1'b0;

  int fail_count;
  int beats_waiting;
  int cmds_seen;
  int releases_seen;

  // stimulus bookkeeping
  logic               idling_on   = 1'b0;
  logic [BYTES_W-1:0] budget_now  = '0;
  int                 items_sent  = 0;
  int                 budgets_used = 0;
  int                 stall_left  = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  byte_budget_lru_cache_tracker_core #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lru_tracker_checker #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tuser    (out_tuser),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .drain_done   (drain_done),
    .fail_count   (fail_count),
    .beats_waiting(beats_waiting),
    .cmds_seen    (cmds_seen),
    .releases_seen(releases_seen)
  );

  // Result side: drop tready for bursts of random length while idling is on,
  // otherwise hold it high. A burst already begun runs to its end.
  always @(posedge clk) begin
    if (idling_on && stall_left == 0 && $urandom_range(0, 3) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Send one command beat. valid stays high on return so back-to-back beats
  // need no drop; a gap lowers it first and only then waits.
  task automatic send_cmd(input logic [CMD_W-1:0]  cmd,
                          input logic [3:0]        idx,
                          input logic [SIZE_W-1:0] size);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, size, idx};
    do @(posedge clk); while (!in_tready);
    // ignored touches and the undefined code do not count towards the total
    if (cmd != CMD_UNUSED && !(cmd == CMD_TOUCH && budget_now == '0)) items_sent++;
  endtask

  // Wait until every predicted beat has left the block. The count from the
  // checker is registered, so wait for the next edge before trusting it.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_waiting != 0) @(posedge clk);
  endtask

  // Budget write; only called with the block idle.
  task automatic write_budget(input logic [BYTES_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    budget_now = value;
    budgets_used++;
  endtask

  // One random command: mostly touches so the list fills and evicts, some
  // removes, the odd evict-all and the odd undefined code as noise.
  task automatic send_random(input logic [SIZE_W-1:0] size_cap);
    logic [SIZE_W-1:0] size;
    int                pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0:       size = '0;
      1:       size = size_cap;
      default: size = (size_cap == '1) ? $urandom : $urandom_range(0, size_cap);
    endcase
    if (pick < 70)      send_cmd(CMD_TOUCH, 4'($urandom_range(0, 15)), size);
    else if (pick < 90) send_cmd(CMD_REMOVE, 4'($urandom_range(0, 15)), size);
    else if (pick < 95) send_cmd(CMD_EVICT_ALL, 4'($urandom_range(0, 15)), size);
    else                send_cmd(CMD_UNUSED, 4'($urandom_range(0, 15)), size);
  endtask

  initial begin
    int                 p;
    int                 i;
    int                 j;
    int                 tmp;
    int                 start;
    int                 order [NUM_BLOCKS];
    logic [SIZE_W-1:0]  size_cap;
    logic [BYTES_W-1:0] phase_budget;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---------------------------------------------------
    // budget is zero out of reset: touch ignored, others still applied
    send_cmd(CMD_TOUCH, 4'd5, 32'd100);
    send_cmd(CMD_REMOVE, 4'd5, 32'd0);
    send_cmd(CMD_EVICT_ALL, 4'd0, 32'd0);
    send_cmd(CMD_UNUSED, 4'd15, 32'hFFFF_FFFF);
    drain();

    write_budget(48'd1000);
    send_cmd(CMD_TOUCH, 4'd0, 32'd0);
    send_cmd(CMD_TOUCH, 4'd15, 32'd400);
    send_cmd(CMD_TOUCH, 4'd3, 32'd500);
    send_cmd(CMD_TOUCH, 4'd15, 32'd7);          // held, not newest: move up
    send_cmd(CMD_TOUCH, 4'd15, 32'd7);          // held and newest: no change
    send_cmd(CMD_TOUCH, 4'd7, 32'd300);         // over budget: oldest go
    send_cmd(CMD_TOUCH, 4'd9, 32'hFFFF_FFFF);   // huge: all but itself go
    send_cmd(CMD_REMOVE, 4'd9, 32'd0);
    send_cmd(CMD_REMOVE, 4'd9, 32'd0);          // no longer held
    send_cmd(CMD_TOUCH, 4'd4, 32'd50);
    send_cmd(CMD_TOUCH, 4'd6, 32'd60);
    drain();

    // zero budget with blocks held: touch ignored, remove still applied
    write_budget(48'd0);
    send_cmd(CMD_TOUCH, 4'd4, 32'd1);
    send_cmd(CMD_REMOVE, 4'd4, 32'd0);
    drain();

    // smallest budget: a new block pushes out older ones while the total exceeds it
    write_budget(48'd1);
    send_cmd(CMD_TOUCH, 4'd1, 32'd5);
    send_cmd(CMD_TOUCH, 4'd2, 32'd0);
    send_cmd(CMD_TOUCH, 4'd10, 32'd1);
    drain();

    // --- random part -----------------------------------------------------
    for (p = 0; p < 6; p++) begin
      idling_on = (p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case (p)
        0: begin
          phase_budget = BYTES_MAX;
          size_cap     = '1;
        end
        1: begin
          phase_budget = BYTES_W'($urandom_range(1, 1 << 20));
          size_cap     = 32'd1 << 18;
        end
        2: begin
          phase_budget = 48'd1;
          size_cap     = 32'd3;
        end
        3: begin
          phase_budget = {12'd0, 4'($urandom_range(1, 15)), 32'($urandom)};
          size_cap     = '1;
        end
        4: begin
          phase_budget = BYTES_W'($urandom_range(1, 4000));
          size_cap     = 32'd1000;
        end
        default: begin
          phase_budget = BYTES_W'($urandom_range(1, 1 << 16));
          size_cap     = 32'd1 << 14;
        end
      endcase
      write_budget(phase_budget);

      // fill every entry in shuffled order, then release the lot in one go
      if (p == 0) begin
        for (i = 0; i < NUM_BLOCKS; i++) order[i] = i;
        for (i = NUM_BLOCKS - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (i = 0; i < NUM_BLOCKS; i++) send_cmd(CMD_TOUCH, 4'(order[i]), $urandom);
        send_cmd(CMD_EVICT_ALL, 4'($urandom_range(0, 15)), $urandom);
      end

      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random(size_cap);
      drain();
    end

    // settle: let any stray beat show up before the leftover check
    repeat (20) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d commands under %0d budget settings, %0d blocks released.",
             cmds_seen, budgets_used, releases_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Timed out with %0d beats still expected", beats_waiting);
    $display("TEST FAILED");
    $finish;
  end

endmodule
